// ===== rtl/core/ppm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_pkg
// Shared types, codes and constants for the PPM frame decoder.
// ----------------------------------------------------------------------------
package ppm_pkg;

  // Slot store geometry
  localparam int CHANNEL_COUNT = 8;
  localparam int SLOT_IDX_W    = $clog2(CHANNEL_COUNT);
  localparam int SLOT_CNT_W    = $clog2(CHANNEL_COUNT + 1);

  // Field and register widths
  localparam int TIME_W  = 32;
  localparam int WIDTH_W = 16;
  localparam int CHAN_W  = 3;
  localparam int PCT_W   = 8;
  localparam int CFG_IDX_W = 2;

  // Percent scaling: quotient (w - min) * 200 / span never exceeds 200
  localparam int PCT_SPAN  = 200;
  localparam int QUOT_W    = 8;
  localparam int NUMER_W   = WIDTH_W + QUOT_W;
  localparam int DIV_CNT_W = $clog2(QUOT_W);

  // Reset values
  localparam logic [WIDTH_W-1:0] RESET_SLOT_WIDTH = WIDTH_W'(1500);
  localparam logic [WIDTH_W-1:0] RESET_MIN_WIDTH  = WIDTH_W'(1000);
  localparam logic [WIDTH_W-1:0] RESET_MAX_WIDTH  = WIDTH_W'(2000);
  localparam logic [WIDTH_W-1:0] RESET_FRAME_GAP  = WIDTH_W'(2500);

  localparam logic signed [PCT_W-1:0] PCT_MIN  = -PCT_W'(100);
  localparam logic signed [PCT_W-1:0] PCT_MAX  = PCT_W'(100);
  localparam logic signed [PCT_W-1:0] PCT_ZERO = '0;
  localparam logic [PCT_W-1:0]        PCT_OFFSET = PCT_W'(100);

  // Operation codes
  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_READ    = 2'd0;
  localparam logic [1:0] STATUS_STORED  = 2'd1;
  localparam logic [1:0] STATUS_SYNC    = 2'd2;
  localparam logic [1:0] STATUS_DROPPED = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_GAP = 2'd2;

  // Input transaction
  typedef struct packed {
    logic              operation;
    logic [TIME_W-1:0] timestamp;
    logic [CHAN_W-1:0] channel;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic [1:0]              status;
    logic [CHAN_W-1:0]       slot;
    logic [WIDTH_W-1:0]      width;
    logic signed [PCT_W-1:0] percent;
  } out_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_REPLY
  } state_t;

endpackage

// ===== rtl/core/ppm_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_divider
// Restoring divider, one quotient bit per cycle, for the percent scaling.
// The quotient is known to fit in QUOT_W bits.
// ----------------------------------------------------------------------------
module ppm_divider (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [ppm_pkg::NUMER_W-1:0]       numer,
  input  logic [ppm_pkg::WIDTH_W-1:0]       denom,
  output logic                              done,
  output logic [ppm_pkg::QUOT_W-1:0]        quotient
);

  logic                            busy;
  logic [ppm_pkg::DIV_CNT_W-1:0]   count;
  logic [ppm_pkg::NUMER_W-1:0]     rem;
  logic [ppm_pkg::NUMER_W-1:0]     dsh;
  logic [ppm_pkg::QUOT_W-1:0]      quot;
  logic                            fits;

  // Trial subtract of the shifted divisor
  assign fits     = (rem >= dsh);
  assign done     = busy && (count == '0);
  assign quotient = quot;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= ppm_pkg::DIV_CNT_W'(ppm_pkg::QUOT_W - 1);
    end else if (busy) begin
      if (count == '0) begin
        busy <= 1'b0;
      end else begin
        count <= count - 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= numer;
      dsh  <= ppm_pkg::NUMER_W'(denom) << (ppm_pkg::QUOT_W - 1);
      quot <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quot <= {quot[ppm_pkg::QUOT_W-2:0], fits};
      dsh  <= dsh >> 1;
    end
  end

endmodule

// ===== rtl/core/ppm_frame_decoder.sv =====
`timescale 1ns / 1ps
// An edge, or a read that clamps (or has an empty span), gives its result in
// the output register in the cycle after acceptance; a scaled read waits in
// ST_DIVIDE as the divider resolves one quotient bit a cycle, then in ST_REPLY
// until the output is free. One transaction at a time; edges 1 per cycle while
// the output is not stalled. Reset: synchronous; clears slot counter and edge
// time, slots read 1500, registers return to 1000 / 2000 / 2500.
// ----------------------------------------------------------------------------
// ppm_frame_decoder
// PPM stream decoder: measures edge intervals into channel slots and
// returns stored widths scaled to percent.
// ----------------------------------------------------------------------------
module ppm_frame_decoder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ppm_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ppm_pkg::out_t                     out_data,
  input  logic                              cfg_write,
  input  logic [ppm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppm_pkg::WIDTH_W-1:0]       cfg_data
);

  ppm_pkg::state_t state, state_next;

  logic [ppm_pkg::WIDTH_W-1:0]    min_width;
  logic [ppm_pkg::WIDTH_W-1:0]    max_width;
  logic [ppm_pkg::WIDTH_W-1:0]    frame_gap;
  logic [ppm_pkg::TIME_W-1:0]     prev_time;
  logic [ppm_pkg::SLOT_CNT_W-1:0] next_slot;
  logic [ppm_pkg::WIDTH_W-1:0]    channel_widths [ppm_pkg::CHANNEL_COUNT];
  logic [ppm_pkg::CHAN_W-1:0]     rd_slot;
  logic [ppm_pkg::WIDTH_W-1:0]    rd_width;

  logic                           accept;
  logic                           out_free;
  logic                           out_load;
  ppm_pkg::out_t                  out_next;

  logic [ppm_pkg::TIME_W-1:0]     diff;
  logic [ppm_pkg::WIDTH_W-1:0]    diff_sat;
  logic                           is_sync;
  logic                           slot_free;
  logic                           store_en;
  logic                           chan_ok;
  logic [ppm_pkg::WIDTH_W-1:0]    rd_value;
  logic [ppm_pkg::WIDTH_W-1:0]    span;
  logic [ppm_pkg::WIDTH_W-1:0]    offset;
  logic [ppm_pkg::NUMER_W-1:0]    numer;
  logic                           div_start;
  logic                           div_done;
  logic [ppm_pkg::QUOT_W-1:0]     quotient;

  // Handshake
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ppm_pkg::ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  // Edge interval and frame sync detect
  assign diff      = in_data.timestamp - prev_time;
  assign diff_sat  = (|diff[ppm_pkg::TIME_W-1:ppm_pkg::WIDTH_W]) ? '1
                     : diff[ppm_pkg::WIDTH_W-1:0];
  assign is_sync   = diff > ppm_pkg::TIME_W'(frame_gap);
  assign slot_free = next_slot < ppm_pkg::SLOT_CNT_W'(ppm_pkg::CHANNEL_COUNT);

  // Read path: slot lookup and divider operands
  assign chan_ok  = ppm_pkg::SLOT_CNT_W'(in_data.channel)
                    < ppm_pkg::SLOT_CNT_W'(ppm_pkg::CHANNEL_COUNT);
  assign rd_value = chan_ok ? channel_widths[in_data.channel[ppm_pkg::SLOT_IDX_W-1:0]]
                    : '0;
  assign span     = max_width - min_width;
  assign offset   = rd_value - min_width;
  assign numer    = ppm_pkg::NUMER_W'(offset) * ppm_pkg::NUMER_W'(ppm_pkg::PCT_SPAN);

  ppm_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (numer),
    .denom    (span),
    .done     (div_done),
    .quotient (quotient)
  );

  // Sequencer: next state and result assembly
  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    div_start  = 1'b0;
    store_en   = 1'b0;
    out_next   = '0;
    case (state)
      ppm_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data.operation == ppm_pkg::OP_EDGE) begin
            out_load       = 1'b1;
            out_next.width = diff_sat;
            if (is_sync) begin
              out_next.status = ppm_pkg::STATUS_SYNC;
            end else if (slot_free) begin
              store_en        = 1'b1;
              out_next.status = ppm_pkg::STATUS_STORED;
              out_next.slot   = ppm_pkg::CHAN_W'(next_slot);
            end else begin
              out_next.status = ppm_pkg::STATUS_DROPPED;
            end
          end else begin
            out_next.status = ppm_pkg::STATUS_READ;
            out_next.slot   = in_data.channel;
            out_next.width  = rd_value;
            if (!chan_ok) begin
              out_load = 1'b1;
            end else if (rd_value < min_width) begin
              out_load         = 1'b1;
              out_next.percent = ppm_pkg::PCT_MIN;
            end else if (rd_value > max_width) begin
              out_load         = 1'b1;
              out_next.percent = ppm_pkg::PCT_MAX;
            end else if (span == '0) begin
              out_load         = 1'b1;
              out_next.percent = ppm_pkg::PCT_ZERO;
            end else begin
              div_start  = 1'b1;
              state_next = ppm_pkg::ST_DIVIDE;
            end
          end
        end
      end
      ppm_pkg::ST_DIVIDE: begin
        if (div_done) begin
          state_next = ppm_pkg::ST_REPLY;
        end
      end
      ppm_pkg::ST_REPLY: begin
        out_next.status  = ppm_pkg::STATUS_READ;
        out_next.slot    = rd_slot;
        out_next.width   = rd_width;
        out_next.percent = quotient - ppm_pkg::PCT_OFFSET;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ppm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ppm_pkg::ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_width <= ppm_pkg::RESET_MIN_WIDTH;
      max_width <= ppm_pkg::RESET_MAX_WIDTH;
      frame_gap <= ppm_pkg::RESET_FRAME_GAP;
    end else if (cfg_write) begin
      case (cfg_index)
        ppm_pkg::REG_MIN_WIDTH: min_width <= cfg_data;
        ppm_pkg::REG_MAX_WIDTH: max_width <= cfg_data;
        ppm_pkg::REG_FRAME_GAP: frame_gap <= cfg_data;
        default: ;
      endcase
    end
  end

  // Edge timing and slot counter
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time <= '0;
      next_slot <= '0;
    end else if (accept && in_data.operation == ppm_pkg::OP_EDGE) begin
      prev_time <= in_data.timestamp;
      if (is_sync) begin
        next_slot <= '0;
      end else if (slot_free) begin
        next_slot <= next_slot + 1'b1;
      end
    end
  end

  // Channel slot store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ppm_pkg::CHANNEL_COUNT; i++) begin
        channel_widths[i] <= ppm_pkg::RESET_SLOT_WIDTH;
      end
    end else if (store_en) begin
      channel_widths[next_slot[ppm_pkg::SLOT_IDX_W-1:0]] <= diff_sat;
    end
  end

  // Read context held while the divider runs
  always_ff @(posedge clk) begin
    if (div_start) begin
      rd_slot  <= in_data.channel;
      rd_width <= rd_value;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
  end

endmodule

// ===== test/tb_ppm_frame_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ppm_frame_decoder
// Self-checking bench for the PPM frame decoder. Directed edges and reads
// cover the reset state, frame sync at the gap boundary, slot overflow,
// percent clamping and timestamp wrap. Randomised frames then run under
// several register settings, with bursty input and a stalling receiver.
// Every result is compared field by field against an in-bench decoder.
// ----------------------------------------------------------------------------
module tb_ppm_frame_decoder;

  localparam int CYCLE_LIMIT = 600_000;

  // Tracks decoder state and holds the replies still owed by the block
  class decode_ledger;
    logic [ppm_pkg::TIME_W-1:0]  last_edge;
    int unsigned                 next_slot;
    logic [ppm_pkg::WIDTH_W-1:0] slot_width [ppm_pkg::CHANNEL_COUNT];
    logic [ppm_pkg::WIDTH_W-1:0] min_w, max_w, gap_w;
    ppm_pkg::out_t               pending_replies [$];
    int                          errors;

    function new();
      last_edge = '0;
      next_slot = 0;
      foreach (slot_width[i]) slot_width[i] = 16'd1500;
      min_w  = 16'd1000;
      max_w  = 16'd2000;
      gap_w  = 16'd2500;
      errors = 0;
    endfunction

    function void set_reg(logic [ppm_pkg::CFG_IDX_W-1:0] idx,
                          logic [ppm_pkg::WIDTH_W-1:0] v);
      case (idx)
        ppm_pkg::REG_MIN_WIDTH: min_w = v;
        ppm_pkg::REG_MAX_WIDTH: max_w = v;
        ppm_pkg::REG_FRAME_GAP: gap_w = v;
        default: ;
      endcase
    endfunction

    // Stored width to percent, truncating division
    function logic signed [ppm_pkg::PCT_W-1:0] to_percent(logic [ppm_pkg::WIDTH_W-1:0] w);
      int span;
      int q;
      if (w < min_w) return -8'sd100;
      if (w > max_w) return 8'sd100;
      span = int'(max_w) - int'(min_w);
      if (span == 0) return 8'sd0;
      q = (int'(w) - int'(min_w)) * 200 / span - 100;
      return q[ppm_pkg::PCT_W-1:0];
    endfunction

    function ppm_pkg::out_t decode(ppm_pkg::in_t item);
      ppm_pkg::out_t r;
      logic [ppm_pkg::TIME_W-1:0] diff;
      r = '0;
      if (item.operation == ppm_pkg::OP_EDGE) begin
        diff      = item.timestamp - last_edge;
        last_edge = item.timestamp;
        r.width   = (diff > 32'h0000_FFFF) ? 16'hFFFF : diff[ppm_pkg::WIDTH_W-1:0];
        if (diff > {16'h0000, gap_w}) begin
          next_slot = 0;
          r.status  = ppm_pkg::STATUS_SYNC;
        end else if (next_slot < ppm_pkg::CHANNEL_COUNT) begin
          slot_width[next_slot] = r.width;
          r.slot    = next_slot[ppm_pkg::CHAN_W-1:0];
          next_slot = next_slot + 1;
          r.status  = ppm_pkg::STATUS_STORED;
        end else begin
          r.status  = ppm_pkg::STATUS_DROPPED;
        end
      end else begin
        r.status  = ppm_pkg::STATUS_READ;
        r.slot    = item.channel;
        r.width   = slot_width[item.channel];
        r.percent = to_percent(r.width);
      end
      return r;
    endfunction

    function void note_transaction(ppm_pkg::in_t item);
      pending_replies.push_back(decode(item));
    endfunction

    function void compare(string what, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_result(ppm_pkg::out_t got);
      ppm_pkg::out_t want;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result, actual status %0d slot %0d width %0d percent %0d",
                 $time, got.status, got.slot, got.width, got.percent);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      compare("status", int'(want.status), int'(got.status));
      compare("slot", int'(want.slot), int'(got.slot));
      compare("width", int'(want.width), int'(got.width));
      compare("percent", int'(want.percent), int'(got.percent));
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  ppm_pkg::in_t                  in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  ppm_pkg::out_t                 out_data;
  logic                          cfg_write = 1'b0;
  logic [ppm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ppm_pkg::WIDTH_W-1:0]   cfg_data = '0;

  decode_ledger                ledger;
  int unsigned                 sent_count = 0;
  int unsigned                 burst_left = 0;
  int unsigned                 reply_count = 0;
  int unsigned                 hold_left = 0;
  int unsigned                 rx_mode = 0;
  int unsigned                 rx_tick = 0;
  int unsigned                 cycle_count = 0;
  logic [ppm_pkg::TIME_W-1:0]  stamp = '0;
  logic [ppm_pkg::WIDTH_W-1:0] cfg_min = 16'd1000;
  logic [ppm_pkg::WIDTH_W-1:0] cfg_max = 16'd2000;
  logic [ppm_pkg::WIDTH_W-1:0] cfg_gap = 16'd2500;

  ppm_frame_decoder DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: changing stall pattern, plus long hold-offs every few hundred replies
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        ledger.check_result(out_data);
        reply_count++;
        if (reply_count % 300 == 150) hold_left = $urandom_range(120, 250);
      end
      if (rx_tick == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_tick = $urandom_range(16, 96);
      end
      rx_tick--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 1) == 0);
          2:       out_ready <= ($urandom_range(0, 9) != 0);
          default: out_ready <= (cycle_count[2:0] != 3'd0);
        endcase
      end
    end
  end

  // Offer one transaction and wait for it to be taken
  task automatic send(input ppm_pkg::in_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    ledger.note_transaction(item);
    sent_count++;
  endtask

  // Bursts of random length with random gaps between them
  task automatic offer(input ppm_pkg::in_t item);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 7))
        0, 1:    gap = 0;
        7:       gap = $urandom_range(13, 40);
        default: gap = $urandom_range(1, 12);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    send(item);
  endtask

  task automatic edge_at(input logic [ppm_pkg::TIME_W-1:0] ts);
    ppm_pkg::in_t item;
    item.operation = ppm_pkg::OP_EDGE;
    item.timestamp = ts;
    item.channel   = ppm_pkg::CHAN_W'($urandom);
    stamp = ts;
    offer(item);
  endtask

  task automatic edge_after(input logic [ppm_pkg::TIME_W-1:0] interval);
    edge_at(stamp + interval);
  endtask

  task automatic read_item(input logic [ppm_pkg::CHAN_W-1:0] ch);
    ppm_pkg::in_t item;
    item.operation = ppm_pkg::OP_READ;
    item.timestamp = $urandom;
    item.channel   = ch;
    offer(item);
  endtask

  // Random channel for a read
  function automatic logic [ppm_pkg::CHAN_W-1:0] any_channel();
    return ppm_pkg::CHAN_W'($urandom_range(0, 7));
  endfunction

  // Interval that normally lands in a channel slot
  function automatic logic [ppm_pkg::TIME_W-1:0] pulse_interval();
    int unsigned lo, hi;
    lo = (cfg_min < cfg_max) ? 32'(cfg_min) : 32'(cfg_max);
    hi = (cfg_min < cfg_max) ? 32'(cfg_max) : 32'(cfg_min);
    lo = (lo > 100) ? lo - 100 : 0;
    hi = (hi + 100 > 65535) ? 65535 : hi + 100;
    case ($urandom_range(0, 9))
      0:          return {16'h0000, cfg_gap};
      1:          return '0;
      2, 3, 4:    return $urandom_range(0, 32'(cfg_gap));
      default:    return $urandom_range(lo, hi);
    endcase
  endfunction

  // Interval that is always a frame sync
  function automatic logic [ppm_pkg::TIME_W-1:0] sync_interval();
    if ($urandom_range(0, 4) == 0) return $urandom | 32'h0001_0000;
    return {16'h0000, cfg_gap} + 32'd1 + $urandom_range(0, 2000);
  endfunction

  task automatic send_frame();
    int unsigned nch;
    edge_after(sync_interval());
    nch = $urandom_range(0, 11);
    repeat (nch) begin
      edge_after(pulse_interval());
      if ($urandom_range(0, 5) == 0) read_item(any_channel());
    end
    repeat ($urandom_range(0, 2)) read_item(any_channel());
  endtask

  // Mostly well-formed frames, some stray reads, noise edges and early syncs
  task automatic random_traffic(input int unsigned n);
    int unsigned target;
    int unsigned choice;
    target = sent_count + n;
    while (sent_count < target) begin
      choice = $urandom_range(0, 19);
      if (choice < 13)      send_frame();
      else if (choice < 16) read_item(any_channel());
      else if (choice < 18) edge_at($urandom);
      else                  edge_after({16'h0000, cfg_gap} + $urandom_range(1, 3));
    end
  endtask

  // Stop offering and wait until every reply has come back
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (ledger.pending_replies.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_config(input logic [ppm_pkg::WIDTH_W-1:0] mn, mx, gp);
    cfg_write <= 1'b1;
    cfg_index <= ppm_pkg::REG_MIN_WIDTH;
    cfg_data  <= mn;
    @(posedge clk);
    cfg_index <= ppm_pkg::REG_MAX_WIDTH;
    cfg_data  <= mx;
    @(posedge clk);
    cfg_index <= ppm_pkg::REG_FRAME_GAP;
    cfg_data  <= gp;
    @(posedge clk);
    cfg_write <= 1'b0;
    ledger.set_reg(ppm_pkg::REG_MIN_WIDTH, mn);
    ledger.set_reg(ppm_pkg::REG_MAX_WIDTH, mx);
    ledger.set_reg(ppm_pkg::REG_FRAME_GAP, gp);
    cfg_min = mn;
    cfg_max = mx;
    cfg_gap = gp;
  endtask

  // Reset-state reads, gap boundary, overflow, clamping, wrap
  task automatic directed_checks();
    read_item(3'd0);
    read_item(3'd7);
    edge_at(32'd500);          // first edge, measured from zero
    edge_after(32'd2501);      // one above the gap: sync
    edge_after(32'd2500);      // exactly the gap: stored
    edge_after(32'd999);
    edge_after(32'd1000);
    edge_after(32'd2000);
    edge_after(32'd2001);
    edge_after(32'd1500);
    edge_after(32'd1999);
    edge_after(32'd0);
    edge_after(32'd1200);      // all slots full: dropped
    for (int i = 0; i < ppm_pkg::CHANNEL_COUNT; i++) read_item(i[ppm_pkg::CHAN_W-1:0]);
    edge_at(32'hFFFF_FFFF);    // long interval, width saturates
    edge_at(32'h0000_01F3);    // wraps through zero
    edge_at(32'h0000_0000);    // backwards step: huge interval
  endtask

  initial begin
    ledger = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    directed_checks();
    random_traffic(300);
    drain();

    // Full range, widest gap
    set_config(16'h0000, 16'hFFFF, 16'hFFFF);
    random_traffic(250);
    drain();

    // Empty span
    set_config(16'd1234, 16'd1234, 16'd3000);
    random_traffic(200);
    drain();

    // Min above max
    set_config(16'd3000, 16'd1000, 16'd4000);
    random_traffic(200);
    drain();

    // Zero gap: only zero intervals are stored
    set_config(16'h0000, 16'h0000, 16'h0000);
    random_traffic(150);
    drain();

    repeat (3) begin
      set_config(ppm_pkg::WIDTH_W'($urandom), ppm_pkg::WIDTH_W'($urandom),
                 ppm_pkg::WIDTH_W'($urandom));
      random_traffic(180);
      drain();
    end

    set_config(16'd1000, 16'd2000, 16'd2500);
    random_traffic(150);
    drain();

    if (ledger.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
